// ----- src/vumlbl_pkg.sv -----
// Shared types and constants for the VU meter level tracker.
// No dependencies; imported by every module of the block.
package vumlbl_pkg;

  // LED strip geometry
  localparam int LED_COUNT = 64;
  localparam int HALF_LEDS = LED_COUNT / 2;
  localparam int LEN_W     = 6;

  // Fixed-point constants (Q16.16 levels, Q10.14 bar tracks)
  localparam logic [31:0] FULL_SCALE   = 32'd32768000;  // 500.0
  localparam logic [15:0] DECAY_MUL    = 16'd64225;     // 0.98
  localparam logic [8:0]  LEVEL_SCALE  = 9'd500;
  localparam logic [8:0]  AVG_IN_MUL   = 9'd393;        // 0.006
  localparam logic [16:0] AVG_KEEP_MUL = 17'd130286;    // 2 * 0.994
  localparam logic [16:0] CURVE_L_MAX  = 17'd128000;
  localparam logic [20:0] MAXL_RECIP   = 21'd1677722;   // ceil(2^23 / 5), exact below 2^20
  localparam logic [3:0]  MAXL_MUL     = 4'd9;
  localparam int          TRACK_FRAC   = 14;
  localparam logic [15:0] RAINBOW_STEP = 16'd51;
  localparam logic [15:0] BAR_HUE_STEP = 16'd77;

  // Display modes
  localparam logic [1:0] MODE_BLANK   = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_BARS    = 2'd2;

  // Register indexes
  typedef enum logic [2:0] {
    REG_NOISE_FLOOR = 3'd0,
    REG_INPUT_GAIN  = 3'd1,
    REG_REFERENCE   = 3'd2,
    REG_TIMEOUT     = 3'd3,
    REG_MIN_DRAW    = 3'd4,
    REG_RISE_RATE   = 3'd5,
    REG_FALL_RATE   = 3'd6,
    REG_MONO_MODE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] noise_floor;
    logic [7:0]  input_gain;
    logic [15:0] reference_level;
    logic [15:0] stream_timeout_ms;
    logic [15:0] min_draw_level;
    logic [7:0]  rise_rate;
    logic [7:0]  fall_rate;
    logic        mono_mode;
  } cfg_t;

  // Per-channel lane status towards the top level
  typedef struct packed {
    logic        done;
    logic [31:0] held;
    logic [31:0] smoothed;
  } lane_out_t;

  typedef struct packed {
    logic [1:0]       display_mode;
    logic [LEN_W-1:0] right_bar_length;
    logic [LEN_W-1:0] left_bar_length;
    logic [7:0]       bar_hue;
    logic [7:0]       rainbow_hue;
    logic [7:0]       peak_norm;
  } result_t;

  typedef struct packed {
    logic    done;
    result_t res;
  } merge_out_t;

endpackage

// ----- src/vumlbl_lane.sv -----
// One channel lane: level from sample sum (serial divider), decay,
// exponent-1.4 curve (bitwise fifth root) and smoothing. Uses vumlbl_pkg.
module vumlbl_lane import vumlbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] frames,
  input  logic [31:0] sum,
  input  cfg_t        cfg,
  input  logic        use_src,
  input  logic [31:0] src_held,
  output lane_out_t   lane_o
);

  typedef enum logic [7:0] {
    L_IDLE = 8'b00000001,
    L_NUM  = 8'b00000010,
    L_DIV  = 8'b00000100,
    L_SQR  = 8'b00001000,
    L_P2   = 8'b00010000,
    L_P4   = 8'b00100000,
    L_P5   = 8'b01000000,
    L_FIN  = 8'b10000000
  } lane_state_t;

  lane_state_t state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [31:0] held_r, held_nxt;
  logic [31:0] smooth_r, smooth_nxt;

  logic [39:0] gain_prod_r, gain_prod_nxt;
  logic [31:0] floor_prod_r, floor_prod_nxt;
  logic [31:0] den_r, den_nxt;
  logic        ref_low_r, ref_low_nxt;
  logic        no_frames_r, no_frames_nxt;
  logic        zero_r, zero_nxt;
  logic        full_r, full_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] dv_r, dv_nxt;
  logic [24:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] l_r, l_nxt;
  logic [33:0] ll_r, ll_nxt;
  logic [11:0] root_r, root_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [23:0] p2_r, p2_nxt;
  logic [47:0] p4_r, p4_nxt;

  logic [39:0] num;
  logic        num_zero, num_full;
  logic [48:0] scaled;
  logic        ge;
  logic [40:0] rem_sub;
  logic [47:0] decay_prod;
  logic [31:0] cur;
  logic [16:0] l_clip;
  logic [11:0] t;
  logic [59:0] p5;
  logic [28:0] curve;
  logic [33:0] smooth_sum;

  // Datapath helpers
  assign num        = gain_prod_r - {8'd0, floor_prod_r};
  assign num_zero   = gain_prod_r <= {8'd0, floor_prod_r};
  assign num_full   = ref_low_r || (num >= {8'd0, den_r});
  assign scaled     = 49'(num) * 49'(LEVEL_SCALE);
  assign ge         = rem_r >= {1'b0, dv_r};
  assign rem_sub    = ge ? (rem_r - {1'b0, dv_r}) : rem_r;
  assign decay_prod = 48'(held_r) * 48'(DECAY_MUL);
  assign cur        = use_src ? src_held : held_r;
  assign l_clip     = (cur[31:8] > 24'(CURVE_L_MAX)) ? CURVE_L_MAX : cur[24:8];
  assign t          = root_r | (12'd1 << bit_r);
  assign p5         = 60'(p4_r) * 60'(t);
  assign curve      = 29'(l_r) * 29'(root_r);
  assign smooth_sum = 34'(curve) * 34'd3 + 34'(smooth_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    done_nxt       = 1'b0;
    held_nxt       = held_r;
    smooth_nxt     = smooth_r;
    gain_prod_nxt  = gain_prod_r;
    floor_prod_nxt = floor_prod_r;
    den_nxt        = den_r;
    ref_low_nxt    = ref_low_r;
    no_frames_nxt  = no_frames_r;
    zero_nxt       = zero_r;
    full_nxt       = full_r;
    rem_nxt        = rem_r;
    dv_nxt         = dv_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    l_nxt          = l_r;
    ll_nxt         = ll_r;
    root_nxt       = root_r;
    bit_nxt        = bit_r;
    p2_nxt         = p2_r;
    p4_nxt         = p4_r;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          gain_prod_nxt  = 40'(sum) * 40'(cfg.input_gain);
          floor_prod_nxt = 32'(cfg.noise_floor) * 32'(frames);
          den_nxt        = 32'(cfg.reference_level - cfg.noise_floor) * 32'(frames);
          ref_low_nxt    = cfg.reference_level <= cfg.noise_floor;
          no_frames_nxt  = frames == 16'd0;
          state_nxt      = L_NUM;
        end
      end
      L_NUM: begin
        zero_nxt = num_zero;
        full_nxt = num_full;
        rem_nxt  = scaled[40:0];
        dv_nxt   = {den_r, 8'd0};
        cnt_nxt  = 5'd24;
        q_nxt    = '0;
        if (no_frames_r) begin
          held_nxt  = decay_prod[47:16];
          state_nxt = L_SQR;
        end else begin
          state_nxt = L_DIV;
        end
      end
      L_DIV: begin
        rem_nxt = {rem_sub[39:0], 1'b0};
        q_nxt   = {q_r[23:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          if (zero_r)      held_nxt = '0;
          else if (full_r) held_nxt = FULL_SCALE;
          else             held_nxt = 32'(q_nxt);
          state_nxt = L_SQR;
        end
      end
      L_SQR: begin
        l_nxt     = l_clip;
        ll_nxt    = 34'(l_clip) * 34'(l_clip);
        root_nxt  = '0;
        bit_nxt   = 4'd11;
        state_nxt = L_P2;
      end
      L_P2: begin
        p2_nxt    = 24'(t) * 24'(t);
        state_nxt = L_P4;
      end
      L_P4: begin
        p4_nxt    = 48'(p2_r) * 48'(p2_r);
        state_nxt = L_P5;
      end
      L_P5: begin
        if (p5 <= {2'b00, ll_r, 24'd0}) root_nxt = t;
        if (bit_r == 4'd0) begin
          state_nxt = L_FIN;
        end else begin
          bit_nxt   = bit_r - 4'd1;
          state_nxt = L_P2;
        end
      end
      L_FIN: begin
        smooth_nxt = smooth_sum[33:2];
        done_nxt   = 1'b1;
        state_nxt  = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= L_IDLE;
      done_r   <= 1'b0;
      held_r   <= '0;
      smooth_r <= '0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      held_r   <= held_nxt;
      smooth_r <= smooth_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    gain_prod_r  <= gain_prod_nxt;
    floor_prod_r <= floor_prod_nxt;
    den_r        <= den_nxt;
    ref_low_r    <= ref_low_nxt;
    no_frames_r  <= no_frames_nxt;
    zero_r       <= zero_nxt;
    full_r       <= full_nxt;
    rem_r        <= rem_nxt;
    dv_r         <= dv_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    l_r          <= l_nxt;
    ll_r         <= ll_nxt;
    root_r       <= root_nxt;
    bit_r        <= bit_nxt;
    p2_r         <= p2_nxt;
    p4_r         <= p4_nxt;
  end

  assign lane_o.done     = done_r;
  assign lane_o.held     = held_r;
  assign lane_o.smoothed = smooth_r;

endmodule

// ----- src/vumlbl_merge.sv -----
// Merging stage: slow average, dynamic maximum, bar targets and tracks,
// level norm and hue accumulators, with one shared serial divider. Uses vumlbl_pkg.
module vumlbl_merge import vumlbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] s_right,
  input  logic [31:0] s_left,
  input  cfg_t        cfg,
  output merge_out_t  merge_o
);

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_SUM    = 7'b0000010,
    M_MAXL   = 7'b0000100,
    M_DIVSET = 7'b0001000,
    M_DIV    = 7'b0010000,
    M_POST   = 7'b0100000,
    M_FIN    = 7'b1000000
  } merge_state_t;

  typedef enum logic [1:0] {
    DIV_LEN_R = 2'd0,
    DIV_LEN_L = 2'd1,
    DIV_NORM  = 2'd2
  } div_sel_t;

  merge_state_t state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [31:0] avg_r, avg_nxt;
  logic [23:0] trk_right_r, trk_right_nxt;
  logic [23:0] trk_left_r, trk_left_nxt;
  logic [15:0] hue_r, hue_nxt;
  logic [15:0] rainbow_r, rainbow_nxt;

  logic [41:0] p_in_r, p_in_nxt;
  logic [48:0] p_keep_r, p_keep_nxt;
  div_sel_t    sel_r, sel_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [56:0] dv_r, dv_nxt;
  logic [23:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [17:0] maxl_r, maxl_nxt;
  logic [5:0]  len_right_r, len_right_nxt;
  logic [5:0]  len_left_r, len_left_nxt;
  logic [7:0]  norm_r, norm_nxt;
  result_t     res_r, res_nxt;

  logic [49:0] acc;
  logic [31:0] mx;
  logic [39:0] dividend;
  logic [33:0] divisor;
  logic        ge;
  logic [31:0] thr;
  logic        low;
  logic [35:0] avg_x9;
  logic [40:0] maxl_prod;
  logic [17:0] maxl_q;

  // Bar track follows its target length with separate rise and fall rates
  function automatic logic [23:0] track_step(input logic [23:0] tr, input logic [5:0] len,
                                             input logic [7:0] rise, input logic [7:0] fall);
    logic [23:0] tgt;
    logic [23:0] d;
    logic [31:0] step;
    tgt = 24'({len, 14'd0});
    if (tgt > tr) begin
      d    = tgt - tr;
      step = (32'(d) * 32'(rise) + 32'd255) >> 8;
      track_step = tr + step[23:0];
    end else begin
      d    = tr - tgt;
      step = (32'(d) * 32'(fall) + 32'd255) >> 8;
      track_step = tr - step[23:0];
    end
  endfunction

  assign acc = 50'(p_in_r) + 50'(p_keep_r);
  assign mx  = (s_right > s_left) ? s_right : s_left;
  assign ge  = {17'd0, rem_r} >= dv_r;
  assign thr = 32'({cfg.min_draw_level, 8'd0});
  assign low = (s_right < thr) && (s_left < thr);

  // Dynamic maximum: floor(avg * 9 / 65536) / 5 by reciprocal multiply
  assign avg_x9    = 36'(avg_r) * 36'(MAXL_MUL);
  assign maxl_prod = 41'(avg_x9[35:16]) * 41'(MAXL_RECIP);
  assign maxl_q    = maxl_prod[40:23];

  // Divider operand select
  always_comb begin
    unique case (sel_r)
      DIV_LEN_R: begin
        dividend = 40'(s_right) * 40'(HALF_LEDS);
        divisor  = {maxl_r, 16'd0};
      end
      DIV_LEN_L: begin
        dividend = 40'(s_left) * 40'(HALF_LEDS);
        divisor  = {maxl_r, 16'd0};
      end
      DIV_NORM: begin
        dividend = {mx, 8'd0};
        divisor  = {maxl_r, 16'd0};
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    done_nxt      = 1'b0;
    avg_nxt       = avg_r;
    trk_right_nxt = trk_right_r;
    trk_left_nxt  = trk_left_r;
    hue_nxt       = hue_r;
    rainbow_nxt   = rainbow_r;
    p_in_nxt      = p_in_r;
    p_keep_nxt    = p_keep_r;
    sel_nxt       = sel_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    maxl_nxt      = maxl_r;
    len_right_nxt = len_right_r;
    len_left_nxt  = len_left_r;
    norm_nxt      = norm_r;
    res_nxt       = res_r;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          p_in_nxt   = (42'(s_right) + 42'(s_left)) * 42'(AVG_IN_MUL);
          p_keep_nxt = 49'(avg_r) * 49'(AVG_KEEP_MUL);
          state_nxt  = M_SUM;
        end
      end
      M_SUM: begin
        avg_nxt   = acc[48:17];
        state_nxt = M_MAXL;
      end
      M_MAXL: begin
        maxl_nxt  = (maxl_q == 18'd0) ? 18'd1 : maxl_q;
        sel_nxt   = DIV_LEN_R;
        state_nxt = M_DIVSET;
      end
      M_DIVSET: begin
        rem_nxt   = dividend;
        dv_nxt    = {divisor, 23'd0};
        q_nxt     = '0;
        cnt_nxt   = 5'd23;
        state_nxt = M_DIV;
      end
      M_DIV: begin
        if (ge) rem_nxt = rem_r - dv_r[39:0];
        q_nxt   = {q_r[22:0], ge};
        dv_nxt  = dv_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = M_POST;
      end
      M_POST: begin
        unique case (sel_r)
          DIV_LEN_R: len_right_nxt = (q_r > 24'(HALF_LEDS)) ? 6'(HALF_LEDS) : q_r[5:0];
          DIV_LEN_L: len_left_nxt = (q_r > 24'(HALF_LEDS)) ? 6'(HALF_LEDS) : q_r[5:0];
          DIV_NORM:  norm_nxt = (q_r > 24'd255) ? 8'd255 : q_r[7:0];
          default:   ;
        endcase
        if (sel_r == DIV_NORM) begin
          state_nxt = M_FIN;
        end else begin
          sel_nxt   = div_sel_t'(sel_r + 2'd1);
          state_nxt = M_DIVSET;
        end
      end
      M_FIN: begin
        trk_right_nxt = track_step(trk_right_r, len_right_r, cfg.rise_rate, cfg.fall_rate);
        trk_left_nxt  = track_step(trk_left_r, len_left_r, cfg.rise_rate, cfg.fall_rate);
        if (low) begin
          rainbow_nxt = rainbow_r + RAINBOW_STEP;
          res_nxt.display_mode = MODE_RAINBOW;
        end else begin
          hue_nxt = hue_r + BAR_HUE_STEP + {7'd0, norm_r, 1'b0};
          res_nxt.display_mode = MODE_BARS;
        end
        res_nxt.right_bar_length = trk_right_nxt[TRACK_FRAC +: LEN_W];
        res_nxt.left_bar_length  = trk_left_nxt[TRACK_FRAC +: LEN_W];
        res_nxt.bar_hue          = hue_nxt[15:8];
        res_nxt.rainbow_hue      = rainbow_nxt[15:8];
        res_nxt.peak_norm        = norm_r;
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  // Control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      done_r      <= 1'b0;
      avg_r       <= 32'd50 << 16;
      trk_right_r <= '0;
      trk_left_r  <= '0;
      hue_r       <= '0;
      rainbow_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      avg_r       <= avg_nxt;
      trk_right_r <= trk_right_nxt;
      trk_left_r  <= trk_left_nxt;
      hue_r       <= hue_nxt;
      rainbow_r   <= rainbow_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    p_in_r      <= p_in_nxt;
    p_keep_r    <= p_keep_nxt;
    sel_r       <= sel_nxt;
    rem_r       <= rem_nxt;
    dv_r        <= dv_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    maxl_r      <= maxl_nxt;
    len_right_r <= len_right_nxt;
    len_left_r  <= len_left_nxt;
    norm_r      <= norm_nxt;
    res_r       <= res_nxt;
  end

  assign merge_o.done = done_r;
  assign merge_o.res  = res_r;

endmodule

// ----- src/vu_meter_level_to_bar_length.sv -----
// Stereo VU meter level tracker, top level. Instantiates two vumlbl_lane and
// one vumlbl_merge; uses vumlbl_pkg.
//
// One input beat is one update tick and gives exactly one result beat. A tick
// that is not streaming, or that leaves the stream inactive, yields an all-zero
// result through the emit state. An active tick runs through the two channel
// lanes (the 25-step level divider, skipped without frames, and the 12-bit
// fifth-root search, with the P2, P4 and P5 states for each bit) and then the
// merging stage (its shared divider doing three 24-step divisions). One tick
// is in work at a time; the finished result sits in an output register so the
// next tick can be taken while it waits.
module vu_meter_level_to_bar_length import vumlbl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_streaming,
  input  logic             in_activity,
  input  logic [15:0]      in_frame_count,
  input  logic [31:0]      in_sum_left,
  input  logic [31:0]      in_sum_right,
  input  logic [31:0]      in_now_ms,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_display_mode,
  output logic [LEN_W-1:0] out_right_bar_length,
  output logic [LEN_W-1:0] out_left_bar_length,
  output logic [7:0]       out_bar_hue,
  output logic [7:0]       out_rainbow_hue,
  output logic [7:0]       out_peak_norm,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_LANE  = 4'b0010,
    T_MERGE = 4'b0100,
    T_EMIT  = 4'b1000
  } top_state_t;

  top_state_t  state_r, state_nxt;
  cfg_t        cfg_r, cfg_nxt;
  logic        active_r, active_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;
  result_t     out_res_r, out_res_nxt;

  logic        accept;
  logic        has_act;
  logic [31:0] elapsed;
  logic        run;
  lane_out_t   lane_right, lane_left;
  merge_out_t  merge_out;

  assign in_ready = state_r == T_IDLE;
  assign accept   = in_valid && in_ready;
  assign has_act  = in_activity || (in_frame_count != 16'd0);
  assign elapsed  = in_now_ms - last_time_r;

  // Stream activity with timeout
  always_comb begin
    active_nxt    = active_r;
    last_time_nxt = last_time_r;
    if (accept) begin
      if (!in_streaming) begin
        active_nxt = 1'b0;
      end else if (has_act) begin
        last_time_nxt = in_now_ms;
        active_nxt    = 1'b1;
      end else if (active_r && (elapsed > 32'(cfg_r.stream_timeout_ms))) begin
        active_nxt = 1'b0;
      end
    end
  end

  assign run = in_streaming && active_nxt;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NOISE_FLOOR: cfg_nxt.noise_floor       = cfg_wdata;
        REG_INPUT_GAIN:  cfg_nxt.input_gain        = cfg_wdata[7:0];
        REG_REFERENCE:   cfg_nxt.reference_level   = cfg_wdata;
        REG_TIMEOUT:     cfg_nxt.stream_timeout_ms = cfg_wdata;
        REG_MIN_DRAW:    cfg_nxt.min_draw_level    = cfg_wdata;
        REG_RISE_RATE:   cfg_nxt.rise_rate         = cfg_wdata[7:0];
        REG_FALL_RATE:   cfg_nxt.fall_rate         = cfg_wdata[7:0];
        REG_MONO_MODE:   cfg_nxt.mono_mode         = cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Channel lanes; the left lane curves the right level in mono mode
  vumlbl_lane u_lane_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && run),
    .frames   (in_frame_count),
    .sum      (in_sum_right),
    .cfg      (cfg_r),
    .use_src  (1'b0),
    .src_held (lane_right.held),
    .lane_o   (lane_right)
  );

  vumlbl_lane u_lane_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && run),
    .frames   (in_frame_count),
    .sum      (in_sum_left),
    .cfg      (cfg_r),
    .use_src  (cfg_r.mono_mode),
    .src_held (lane_right.held),
    .lane_o   (lane_left)
  );

  vumlbl_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == T_LANE && lane_right.done),
    .s_right (lane_right.smoothed),
    .s_left  (lane_left.smoothed),
    .cfg     (cfg_r),
    .merge_o (merge_out)
  );

  // Tick sequencing and output register
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (run) begin
            state_nxt = T_LANE;
          end else begin
            res_nxt   = '0;
            state_nxt = T_EMIT;
          end
        end
      end
      T_LANE: begin
        if (lane_right.done) state_nxt = T_MERGE;
      end
      T_MERGE: begin
        if (merge_out.done) begin
          res_nxt   = merge_out.res;
          state_nxt = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      active_r    <= 1'b0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{noise_floor: 16'd150, input_gain: 8'd10, reference_level: 16'd6000,
                       stream_timeout_ms: 16'd5000, min_draw_level: 16'd307,
                       rise_rate: 8'd64, fall_rate: 8'd8, mono_mode: 1'b1};
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_display_mode     = out_res_r.display_mode;
  assign out_right_bar_length = out_res_r.right_bar_length;
  assign out_left_bar_length  = out_res_r.left_bar_length;
  assign out_bar_hue          = out_res_r.bar_hue;
  assign out_rainbow_hue      = out_res_r.rainbow_hue;
  assign out_peak_norm        = out_res_r.peak_norm;

  // Checks
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_right.done == lane_left.done)
    else $error("channel lanes out of step");

  a_blank_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_display_mode == MODE_BLANK |->
      out_right_bar_length == '0 && out_left_bar_length == '0 &&
      out_bar_hue == '0 && out_rainbow_hue == '0 && out_peak_norm == '0)
    else $error("blank result carries data");

  a_bar_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_right_bar_length <= LEN_W'(HALF_LEDS) &&
                  out_left_bar_length <= LEN_W'(HALF_LEDS))
    else $error("bar length beyond half strip");

  a_idle_tick_fast: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_streaming |=> state_r == T_EMIT)
    else $error("non-streaming tick entered the lanes");

endmodule

// ----- test/tb_vu_meter_level_to_bar_length.sv -----
// Self-checking testbench for the VU meter level tracker: random and directed
// ticks, per-field result checks. Depends on src/vumlbl_pkg.sv and the top level.
`timescale 1ns / 1ps

module tb_vu_meter_level_to_bar_length import vumlbl_pkg::*;;

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          DRAIN_CYCLES = 400;
  localparam logic [63:0] FULL_Q16     = 64'd500 << 16;

  typedef struct {
    bit        streaming;
    bit        activity;
    bit [15:0] frame_count;
    bit [31:0] sum_left;
    bit [31:0] sum_right;
    bit [31:0] now_ms;
  } tick_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_streaming = 1'b0;
  logic             in_activity = 1'b0;
  logic [15:0]      in_frame_count = '0;
  logic [31:0]      in_sum_left = '0;
  logic [31:0]      in_sum_right = '0;
  logic [31:0]      in_now_ms = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_display_mode;
  logic [LEN_W-1:0] out_right_bar_length;
  logic [LEN_W-1:0] out_left_bar_length;
  logic [7:0]       out_bar_hue;
  logic [7:0]       out_rainbow_hue;
  logic [7:0]       out_peak_norm;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [15:0]      cfg_wdata = '0;

  vu_meter_level_to_bar_length dut (.*);

  always #2 clk = ~clk;

  // Predicted block state and register copy
  bit [15:0] m_floor, m_ref, m_timeout, m_min_draw;
  bit [7:0]  m_gain, m_rise, m_fall;
  bit        m_mono;
  bit        s_active;
  bit [31:0] s_last_ms, s_held_r, s_held_l, s_smooth_r, s_smooth_l, s_slow_avg;
  bit [31:0] s_track_r, s_track_l;
  bit [15:0] s_hue_acc, s_rainbow_acc;

  tick_t   pending_ticks[$];
  result_t expected_results[$];
  int      errors = 0;
  int      cycles = 0;
  bit      in_took = 1'b0;
  bit      calm = 1'b0;
  bit [31:0] clock_ms = 0;

  function automatic void model_reset();
    m_floor = 150; m_gain = 10; m_ref = 6000; m_timeout = 5000;
    m_min_draw = 307; m_rise = 64; m_fall = 8; m_mono = 1;
    s_active = 0; s_last_ms = 0; s_held_r = 0; s_held_l = 0;
    s_smooth_r = 0; s_smooth_l = 0; s_slow_avg = 32'd50 << 16;
    s_track_r = 0; s_track_l = 0; s_hue_acc = 0; s_rainbow_acc = 0;
  endfunction

  function automatic void model_write(reg_idx_t idx, bit [15:0] v);
    case (idx)
      REG_NOISE_FLOOR: m_floor = v;
      REG_INPUT_GAIN:  m_gain = v[7:0];
      REG_REFERENCE:   m_ref = v;
      REG_TIMEOUT:     m_timeout = v;
      REG_MIN_DRAW:    m_min_draw = v;
      REG_RISE_RATE:   m_rise = v[7:0];
      REG_FALL_RATE:   m_fall = v[7:0];
      REG_MONO_MODE:   m_mono = v[0];
    endcase
  endfunction

  // Average level of one channel in Q16.16, 0..500
  function automatic bit [31:0] pcm_level(bit [31:0] sum, bit [15:0] frames);
    bit [63:0] g, fl, num, den;
    g  = 64'(sum) * m_gain;
    fl = 64'(m_floor) * frames;
    if (g <= fl) return 0;
    num = g - fl;
    if (m_ref <= m_floor) return FULL_Q16[31:0];
    den = 64'(m_ref - m_floor) * frames;
    if (num >= den) return FULL_Q16[31:0];
    return 32'((num * FULL_Q16) / den);
  endfunction

  // Exponent-1.4 curve: l * fifth root of l^2
  function automatic bit [31:0] curve_1p4(bit [31:0] held);
    bit [63:0] l, x, t;
    bit [63:0] r;
    l = held >> 8;
    if (l > CURVE_L_MAX) l = CURVE_L_MAX;
    x = (l * l) << 24;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * t * t * t <= x) r = t;
    end
    return 32'(l * r);
  endfunction

  function automatic bit [31:0] bar_target(bit [31:0] s, bit [31:0] maxl);
    bit [63:0] len;
    len = (64'(HALF_LEDS) * s) / (64'(maxl) << 16);
    return (len > HALF_LEDS) ? HALF_LEDS : 32'(len);
  endfunction

  function automatic bit [31:0] bar_follow(bit [31:0] tr, bit [31:0] len);
    bit [63:0] tgt, d;
    tgt = 64'(len) << TRACK_FRAC;
    if (tgt > tr) begin
      d = tgt - tr;
      tr = tr + 32'((d * m_rise + 255) >> 8);
    end else begin
      d = tr - tgt;
      tr = tr - 32'((d * m_fall + 255) >> 8);
    end
    return tr & 32'hFFFFFF;
  endfunction

  // One tick through the predicted block
  function automatic result_t predict_tick(tick_t t);
    result_t   res;
    bit [31:0] lv_r, lv_l, maxl, mx, norm, thr;
    bit [63:0] acc;
    res = '0;
    if (!t.streaming) begin
      s_active = 0;
      return res;
    end
    if (t.activity || t.frame_count > 0) begin
      s_last_ms = t.now_ms;
      s_active = 1;
    end else if (s_active && (t.now_ms - s_last_ms) > m_timeout) begin
      s_active = 0;
    end
    if (!s_active) return res;

    if (t.frame_count > 0) begin
      s_held_r = pcm_level(t.sum_right, t.frame_count);
      s_held_l = pcm_level(t.sum_left, t.frame_count);
    end else begin
      s_held_r = 32'((64'(s_held_r) * DECAY_MUL) >> 16);
      s_held_l = 32'((64'(s_held_l) * DECAY_MUL) >> 16);
    end
    lv_r = s_held_r;
    lv_l = m_mono ? lv_r : s_held_l;
    s_smooth_r = 32'((64'(curve_1p4(lv_r)) * 3 + s_smooth_r) >> 2);
    s_smooth_l = 32'((64'(curve_1p4(lv_l)) * 3 + s_smooth_l) >> 2);

    acc = (64'(s_smooth_r) + s_smooth_l) * AVG_IN_MUL + 64'(s_slow_avg) * AVG_KEEP_MUL;
    s_slow_avg = 32'(acc >> 17);
    maxl = 32'(((64'(s_slow_avg) * 9) / 5) >> 16);
    if (maxl < 1) maxl = 1;

    s_track_r = bar_follow(s_track_r, bar_target(s_smooth_r, maxl));
    s_track_l = bar_follow(s_track_l, bar_target(s_smooth_l, maxl));

    mx = (s_smooth_r > s_smooth_l) ? s_smooth_r : s_smooth_l;
    acc = (64'(mx) << 8) / (64'(maxl) << 16);
    norm = (acc > 255) ? 255 : 32'(acc);

    thr = 32'(m_min_draw) << 8;
    if (s_smooth_r < thr && s_smooth_l < thr) begin
      s_rainbow_acc = s_rainbow_acc + RAINBOW_STEP;
      res.display_mode = MODE_RAINBOW;
    end else begin
      s_hue_acc = s_hue_acc + BAR_HUE_STEP + 16'(2 * norm);
      res.display_mode = MODE_BARS;
    end
    res.right_bar_length = s_track_r[TRACK_FRAC +: LEN_W];
    res.left_bar_length  = s_track_l[TRACK_FRAC +: LEN_W];
    res.bar_hue          = s_hue_acc[15:8];
    res.rainbow_hue      = s_rainbow_acc[15:8];
    res.peak_norm        = norm[7:0];
    return res;
  endfunction

  // Stimulus helpers
  function automatic tick_t make_tick(bit stream, bit act, bit [15:0] frames,
                                      bit [31:0] sl, bit [31:0] sr, bit [31:0] now);
    tick_t t;
    t.streaming = stream; t.activity = act; t.frame_count = frames;
    t.sum_left = sl; t.sum_right = sr; t.now_ms = now;
    return t;
  endfunction

  function automatic tick_t random_tick();
    int        pick;
    bit [15:0] frames;
    bit [31:0] amp_l, amp_r;
    pick = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(5, 15);
    if (pick < 3) clock_ms = clock_ms + $urandom_range(0, 70000);
    if (pick < 3)
      return make_tick(1'b0, 1'($urandom), 16'($urandom), $urandom, $urandom, clock_ms);
    if (pick < 8)
      return make_tick(1'($urandom), 1'($urandom), 16'($urandom), $urandom, $urandom,
                       $urandom);
    if (pick < 22)
      return make_tick(1'b1, pick < 10, 16'd0, $urandom, $urandom, clock_ms);
    frames = (pick < 26) ? 16'($urandom) : 16'($urandom_range(1, 1000));
    amp_r = (pick < 30) ? $urandom_range(0, 70000) : $urandom_range(0, 900);
    amp_l = ($urandom_range(0, 3) == 0) ? amp_r / 4 : $urandom_range(0, 900);
    return make_tick(1'b1, 1'($urandom), frames, frames * amp_l, frames * amp_r, clock_ms);
  endfunction

  task automatic write_regs(input bit [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= v[i];
      model_write(reg_idx_t'(i), v[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) pending_ticks.push_back(random_tick());
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: next beat at the falling edge, random gaps
  always @(negedge clk) begin
    bit    next_valid;
    tick_t t;
    next_valid = in_valid;
    if (rst_n && (!in_valid || in_took)) begin
      next_valid = 1'b0;
      if (pending_ticks.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        t = pending_ticks.pop_front();
        next_valid     = 1'b1;
        in_streaming   <= t.streaming;
        in_activity    <= t.activity;
        in_frame_count <= t.frame_count;
        in_sum_left    <= t.sum_left;
        in_sum_right   <= t.sum_right;
        in_now_ms      <= t.now_ms;
      end
    end
    in_valid  <= next_valid;
    out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 13);
  end

  // Monitor: predict on accepted ticks, check accepted results
  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    cycles <= cycles + 1;
    in_took <= in_valid && in_ready;
    if (in_valid && in_ready)
      expected_results.push_back(predict_tick(make_tick(in_streaming, in_activity,
        in_frame_count, in_sum_left, in_sum_right, in_now_ms)));
    if (out_valid && out_ready) begin
      got = '{out_display_mode, out_right_bar_length, out_left_bar_length,
              out_bar_hue, out_rainbow_hue, out_peak_norm};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $realtime, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.display_mode !== exp_r.display_mode) begin
          errors++;
          $display("%0t: display_mode exp %0d got %0d", $realtime,
                   exp_r.display_mode, got.display_mode);
        end
        if (got.right_bar_length !== exp_r.right_bar_length) begin
          errors++;
          $display("%0t: right_bar_length exp %0d got %0d", $realtime,
                   exp_r.right_bar_length, got.right_bar_length);
        end
        if (got.left_bar_length !== exp_r.left_bar_length) begin
          errors++;
          $display("%0t: left_bar_length exp %0d got %0d", $realtime,
                   exp_r.left_bar_length, got.left_bar_length);
        end
        if (got.bar_hue !== exp_r.bar_hue) begin
          errors++;
          $display("%0t: bar_hue exp %0d got %0d", $realtime, exp_r.bar_hue, got.bar_hue);
        end
        if (got.rainbow_hue !== exp_r.rainbow_hue) begin
          errors++;
          $display("%0t: rainbow_hue exp %0d got %0d", $realtime,
                   exp_r.rainbow_hue, got.rainbow_hue);
        end
        if (got.peak_norm !== exp_r.peak_norm) begin
          errors++;
          $display("%0t: peak_norm exp %0d got %0d", $realtime,
                   exp_r.peak_norm, got.peak_norm);
        end
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sequence: reset, then phases of register settings
  initial begin
    bit [15:0] regs[8];
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks under reset settings
    pending_ticks.push_back(make_tick(0, 1, 100, 32'hFFFFFFFF, 32'hFFFFFFFF, 10));
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 20));           // inactive, ignored
    pending_ticks.push_back(make_tick(1, 1, 0, 0, 0, 30));           // wakes, decays
    pending_ticks.push_back(make_tick(1, 0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 40));
    pending_ticks.push_back(make_tick(1, 1, 16'hFFFF, 32'hFFFFFFFF, 0, 50));
    pending_ticks.push_back(make_tick(1, 1, 16'hFFFF, 0, 32'hFFFFFFFF, 60));
    pending_ticks.push_back(make_tick(1, 1, 1, 0, 0, 70));
    pending_ticks.push_back(make_tick(1, 1, 100, 15000, 15000, 80)); // between floor and full scale
    pending_ticks.push_back(make_tick(1, 1, 100, 60000, 30000, 90)); // left at full scale
    for (int i = 0; i < 5; i++)
      pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 100 + 10 * i));
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 5090));         // at timeout, stays
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 5091));         // past timeout
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 5150));
    pending_ticks.push_back(make_tick(1, 1, 200, 100000, 400000, 32'hFFFFFFF0));
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 32'd100));      // wrapped time
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 32'd5000));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 32'd5010));
    clock_ms = 32'd6000;
    run_random(120);

    regs = '{16'd0, 16'd255, 16'd65535, 16'd0, 16'd0, 16'd255, 16'd255, 16'd0};
    write_regs(regs);
    run_random(140);

    regs = '{16'd65535, 16'd1, 16'd1, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1};
    write_regs(regs);
    run_random(120);

    regs = '{16'd100, 16'd20, 16'd3000, 16'd50, 16'd100, 16'd128, 16'd32, 16'd0};
    write_regs(regs);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;

    regs = '{16'($urandom_range(0, 400)), 16'($urandom_range(1, 255)),
             16'($urandom), 16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
             16'($urandom), 16'($urandom), 16'($urandom)};
    write_regs(regs);
    run_random(140);

    regs = '{16'd150, 16'd10, 16'd6000, 16'd5000, 16'd307, 16'd64, 16'd8, 16'd1};
    write_regs(regs);
    run_random(160);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- vu_meter_level_to_bar_length.f -----
src/vumlbl_pkg.sv
src/vumlbl_lane.sv
src/vumlbl_merge.sv
src/vu_meter_level_to_bar_length.sv
test/tb_vu_meter_level_to_bar_length.sv
